FILE: design/lpmf_pkg.sv
// Package for the length-prefixed message FIFO: operation and status codes,
// default ring size and the result record type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpmf_pkg;

  // Default ring size: 2^ADDR_BITS byte slots.
  localparam int unsigned ADDR_BITS_DEF = 10;

  // Operation codes on the request channel.
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Status codes on the response channel.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_ROOM   = 3'd1;
  localparam logic [2:0] ST_NOTHING   = 3'd2;
  localparam logic [2:0] ST_STRAY     = 3'd3;
  localparam logic [2:0] ST_EMPTY_MSG = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_out;
    logic        last_of_message;
    logic [15:0] free_space;
  } rsp_t;

endpackage

`default_nettype wire

FILE: design/lpmf_req_if.sv
// Request channel of the length-prefixed message FIFO: valid/ready plus
// one operation item. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lpmf_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] message_length;
  logic [7:0] data_in;

  modport source (output valid, output operation, output message_length,
                  output data_in, input ready);
  modport sink (input valid, input operation, input message_length,
                input data_in, output ready);
endinterface

`default_nettype wire

FILE: design/lpmf_rsp_if.sv
// Response channel of the length-prefixed message FIFO: valid/ready plus
// one result item. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lpmf_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  data_out;
  logic        last_of_message;
  logic [15:0] free_space;

  modport source (output valid, output status, output data_out,
                  output last_of_message, output free_space, input ready);
  modport sink (input valid, input status, input data_out,
                input last_of_message, input free_space, output ready);
endinterface

`default_nettype wire

FILE: design/lpmf_ram.sv
// Generic single-clock RAM: one write port, one read port with registered
// read data (old data on a same-address write). No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lpmf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/length_prefixed_message_fifo.sv
// Length-prefixed message FIFO top level.
// Depends on lpmf_pkg, lpmf_req_if, lpmf_rsp_if and lpmf_ram.
//
// Usage:
//   req_i carries one operation per item: begin a message with its length,
//   write one payload byte, or read the next byte of the head message.
//   rsp_o returns exactly one result item per request item, in order, with a
//   status code, the popped byte, a last-byte flag and the free byte count.
//   Throughput is one item per clock cycle while req_i is ready. A result is
//   registered into the output buffer when its request is accepted.
//   The byte at the read pointer and the one after it are fetched ahead of
//   time from two copies of the ring memory, so a read that pops a length
//   byte and the first payload byte still completes as one request; a write
//   that lands on a prefetched address is forwarded.
//   Reset empties the ring and closes both the write and read message at
//   once; the memory itself is not cleared and no clearing pass is needed.
//   Results wait in a two-entry output buffer. While the receiver stalls,
//   req_i stays ready until both entries are full.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_message_fifo #(
  parameter int unsigned ADDR_BITS = lpmf_pkg::ADDR_BITS_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  lpmf_req_if.sink   req_i,
  lpmf_rsp_if.source rsp_o
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [ADDR_BITS-1:0] rp_q, rp_d, cp_q, cp_d, sp_q, sp_d;
  logic [7:0]           wbl_q, wbl_d, rbl_q, rbl_d;
  logic                 wopen_q, wopen_d, ropen_q, ropen_d;

  logic                 we;
  logic [ADDR_BITS-1:0] waddr;
  logic [7:0]           wdata;
  logic [ADDR_BITS-1:0] raddr_a, raddr_b, free_now, free_next;
  logic [7:0]           ram_a, ram_b, head_byte, next_byte;
  logic                 byp_a_q, byp_b_q;
  logic [7:0]           byp_data_q;

  logic                 accept, pop;
  lpmf_pkg::rsp_t       rsp;

  logic [1:0]           cnt_q;
  logic                 wptr_q, rptr_q;
  lpmf_pkg::rsp_t       oq_q [2];

  assign accept = req_i.valid && req_i.ready;
  assign pop    = rsp_o.valid && rsp_o.ready;

  // Bytes at the read pointer and the next slot, with forwarding of a write
  // that hit the same address in the cycle the read was issued.
  assign head_byte = byp_a_q ? byp_data_q : ram_a;
  assign next_byte = byp_b_q ? byp_data_q : ram_b;

  assign free_now = rp_q - cp_q - ADDR_BITS'(1);

  always_comb begin
    rp_d    = rp_q;
    cp_d    = cp_q;
    sp_d    = sp_q;
    wbl_d   = wbl_q;
    rbl_d   = rbl_q;
    wopen_d = wopen_q;
    ropen_d = ropen_q;
    we      = 1'b0;
    waddr   = sp_q;
    wdata   = req_i.data_in;
    rsp.status          = lpmf_pkg::ST_OK;
    rsp.data_out        = 8'd0;
    rsp.last_of_message = 1'b0;
    if (accept) begin
      case (req_i.operation)
        lpmf_pkg::OP_BEGIN: begin
          // A new begin abandons any unfinished message.
          wopen_d = 1'b0;
          sp_d    = cp_q;
          if ((17'(req_i.message_length) + 17'd1) <= 17'(free_now)) begin
            we    = 1'b1;
            waddr = cp_q;
            wdata = req_i.message_length;
            sp_d  = cp_q + ADDR_BITS'(1);
            if (req_i.message_length == 8'd0) begin
              cp_d = cp_q + ADDR_BITS'(1);
            end else begin
              wbl_d   = req_i.message_length;
              wopen_d = 1'b1;
            end
          end else begin
            rsp.status = lpmf_pkg::ST_NO_ROOM;
          end
        end
        lpmf_pkg::OP_WRITE: begin
          if (wopen_q) begin
            we    = 1'b1;
            waddr = sp_q;
            sp_d  = sp_q + ADDR_BITS'(1);
            wbl_d = wbl_q - 8'd1;
            if (wbl_q == 8'd1) begin
              cp_d    = sp_q + ADDR_BITS'(1);
              wopen_d = 1'b0;
            end
          end else begin
            rsp.status = lpmf_pkg::ST_STRAY;
          end
        end
        lpmf_pkg::OP_READ: begin
          if (ropen_q) begin
            rsp.data_out = head_byte;
            rp_d         = rp_q + ADDR_BITS'(1);
            rbl_d        = rbl_q - 8'd1;
            if (rbl_q == 8'd1) begin
              rsp.last_of_message = 1'b1;
              ropen_d             = 1'b0;
            end
          end else if (rp_q == cp_q) begin
            rsp.status = lpmf_pkg::ST_NOTHING;
          end else if (head_byte == 8'd0) begin
            rsp.status = lpmf_pkg::ST_EMPTY_MSG;
            rp_d       = rp_q + ADDR_BITS'(1);
          end else begin
            // Pop the length byte and the first payload byte together.
            rsp.data_out = next_byte;
            rp_d         = rp_q + ADDR_BITS'(2);
            rbl_d        = head_byte - 8'd1;
            if (head_byte == 8'd1) begin
              rsp.last_of_message = 1'b1;
            end else begin
              ropen_d = 1'b1;
            end
          end
        end
        default: begin
          rsp.status = lpmf_pkg::ST_STRAY;
        end
      endcase
    end
    free_next      = rp_d - cp_d - ADDR_BITS'(1);
    rsp.free_space = 16'(free_next);
  end

  assign raddr_a = rp_d;
  assign raddr_b = rp_d + ADDR_BITS'(1);

  lpmf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram_head (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_a),
    .rdata_o (ram_a)
  );

  lpmf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram_next (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_b),
    .rdata_o (ram_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q    <= '0;
      cp_q    <= '0;
      sp_q    <= '0;
      wbl_q   <= '0;
      rbl_q   <= '0;
      wopen_q <= 1'b0;
      ropen_q <= 1'b0;
      byp_a_q <= 1'b0;
      byp_b_q <= 1'b0;
      cnt_q   <= '0;
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
    end else begin
      rp_q    <= rp_d;
      cp_q    <= cp_d;
      sp_q    <= sp_d;
      wbl_q   <= wbl_d;
      rbl_q   <= rbl_d;
      wopen_q <= wopen_d;
      ropen_q <= ropen_d;
      byp_a_q <= we && (waddr == raddr_a);
      byp_b_q <= we && (waddr == raddr_b);
      if (accept) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      if (accept && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !accept) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata;
    if (accept) begin
      oq_q[wptr_q] <= rsp;
    end
  end

  assign req_i.ready           = (cnt_q != 2'd2);
  assign rsp_o.valid           = (cnt_q != 2'd0);
  assign rsp_o.status          = oq_q[rptr_q].status;
  assign rsp_o.data_out        = oq_q[rptr_q].data_out;
  assign rsp_o.last_of_message = oq_q[rptr_q].last_of_message;
  assign rsp_o.free_space      = oq_q[rptr_q].free_space;

endmodule

`default_nettype wire
